// ===== hdl/tldc_pkg.sv =====
// ----------------------------------------------------------------------------
// Train lever drive controller package
// Shared widths, register indexes, lever codes, drive levels and mode codes.
// ----------------------------------------------------------------------------
package tldc_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned LeverW = 3;
  localparam int unsigned EngineW = 2;
  localparam int unsigned BrakeW = 3;
  localparam int unsigned ModeW = 2;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MAX_ACCEL_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_NO_INPUT_LIMIT = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [CountW-1:0] MAX_ACCEL_LIMIT_RST = 16'd400;
  localparam logic [CountW-1:0] NO_INPUT_LIMIT_RST = 16'd300;

  // Lever codes.
  localparam logic [LeverW-1:0] LEVER_MAX_BRAKE = 3'd0;
  localparam logic [LeverW-1:0] LEVER_MED_BRAKE = 3'd1;
  localparam logic [LeverW-1:0] LEVER_MIN_BRAKE = 3'd2;
  localparam logic [LeverW-1:0] LEVER_IDLE = 3'd3;
  localparam logic [LeverW-1:0] LEVER_MIN_ACCEL = 3'd4;
  localparam logic [LeverW-1:0] LEVER_MED_ACCEL = 3'd5;
  localparam logic [LeverW-1:0] LEVER_MAX_ACCEL = 3'd6;
  localparam logic [LeverW-1:0] LEVER_NONE = 3'd7;

  // Engine levels.
  localparam logic [EngineW-1:0] ENGINE_OFF = 2'd0;
  localparam logic [EngineW-1:0] ENGINE_MIN = 2'd1;
  localparam logic [EngineW-1:0] ENGINE_MED = 2'd2;
  localparam logic [EngineW-1:0] ENGINE_MAX = 2'd3;

  // Brake levels.
  localparam logic [BrakeW-1:0] BRAKE_OFF = 3'd0;
  localparam logic [BrakeW-1:0] BRAKE_MIN = 3'd1;
  localparam logic [BrakeW-1:0] BRAKE_MED = 3'd2;
  localparam logic [BrakeW-1:0] BRAKE_MAX = 3'd3;
  localparam logic [BrakeW-1:0] BRAKE_EMERG = 3'd4;

  // Drive modes.
  localparam logic [ModeW-1:0] MODE_NORMAL = 2'd0;
  localparam logic [ModeW-1:0] MODE_STOP = 2'd1;
  localparam logic [ModeW-1:0] MODE_EMERG = 2'd2;
  localparam logic [ModeW-1:0] MODE_SILENT = 2'd3;

endpackage

// ===== hdl/train_lever_drive_controller.sv =====
// ----------------------------------------------------------------------------
// Train lever drive controller
// Per-tick drive logic: lever decoding, stop hold, emergency latch, full
// acceleration fallback and no-input lockout.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid_i, in_ready_o, lever_code_i,     | request in
//           | stop_request_i, stop_level_i,             |
//           | emergency_request_i                       |
//  out      | out_valid_o, out_ready_i, engine_level_o, | request out
//           | brake_level_o, drive_mode_o               |
//  cfg      | cfg_we_i, cfg_index_i, cfg_data_i         | write only
//
// One request is taken per clock cycle while the output is not stalled; its
// result appears in the cycle after. A single state update carries the request
// ports into the state registers, and these drive the result ports directly.
// A request is taken whenever the result register is empty or being drained
// in the same cycle, so a stalled output holds the input side for as long.
// Reset clears all state and restores the limit registers to 400 and 300.

module train_lever_drive_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [tldc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tldc_pkg::CountW-1:0]       cfg_data_i,
  // Tick requests.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tldc_pkg::LeverW-1:0]       lever_code_i,
  input  logic                              stop_request_i,
  input  logic                              stop_level_i,
  input  logic                              emergency_request_i,
  // Drive results.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tldc_pkg::EngineW-1:0]      engine_level_o,
  output logic [tldc_pkg::BrakeW-1:0]       brake_level_o,
  output logic [tldc_pkg::ModeW-1:0]        drive_mode_o
);

  // Limit registers.
  logic [tldc_pkg::CountW-1:0]  max_accel_limit_q;
  logic [tldc_pkg::CountW-1:0]  no_input_limit_q;

  // Controller state. The drive levels and mode double as the result
  // register, since they only change when a request is taken.
  logic [tldc_pkg::ModeW-1:0]   mode_q, mode_d;
  logic                         stop_cleared_q, stop_cleared_d;
  logic [tldc_pkg::LeverW-1:0]  prev_lever_q, prev_lever_d;
  logic [tldc_pkg::EngineW-1:0] engine_q, engine_d;
  logic [tldc_pkg::BrakeW-1:0]  brake_q, brake_d;
  logic [tldc_pkg::CountW-1:0]  accel_cnt_q, accel_cnt_d;
  logic [tldc_pkg::CountW-1:0]  silence_cnt_q, silence_cnt_d;
  logic                         out_valid_q;

  logic                         in_accept;
  logic                         lever_run;
  logic                         lever_changed;
  logic [tldc_pkg::CountW-1:0]  accel_cnt_inc;
  logic [tldc_pkg::CountW-1:0]  silence_cnt_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // Saturating increments of the tick counters.
  assign accel_cnt_inc   = (accel_cnt_q == '1) ? accel_cnt_q : accel_cnt_q + 1'b1;
  assign silence_cnt_inc = (silence_cnt_q == '1) ? silence_cnt_q : silence_cnt_q + 1'b1;
  assign lever_changed   = (lever_code_i != prev_lever_q);

  always_comb begin
    mode_d         = mode_q;
    stop_cleared_d = stop_cleared_q;
    prev_lever_d   = prev_lever_q;
    engine_d       = engine_q;
    brake_d        = brake_q;
    accel_cnt_d    = accel_cnt_q;
    silence_cnt_d  = silence_cnt_q;
    lever_run      = 1'b0;

    // Mode handling. An emergency wins in every mode and is never left.
    if (emergency_request_i || mode_q == tldc_pkg::MODE_EMERG) begin
      mode_d   = tldc_pkg::MODE_EMERG;
      engine_d = tldc_pkg::ENGINE_OFF;
      brake_d  = tldc_pkg::BRAKE_EMERG;
    end else begin
      unique case (mode_q)
        tldc_pkg::MODE_NORMAL: begin
          if (stop_request_i) begin
            mode_d         = tldc_pkg::MODE_STOP;
            stop_cleared_d = 1'b0;
            engine_d       = tldc_pkg::ENGINE_OFF;
            brake_d        = tldc_pkg::BRAKE_MED;
          end else begin
            lever_run = 1'b1;
          end
        end
        tldc_pkg::MODE_STOP: begin
          if (stop_request_i) begin
            // A new stop event restarts the hold.
            stop_cleared_d = 1'b0;
          end else begin
            stop_cleared_d = stop_cleared_q || !stop_level_i;
            // Release needs the stop pin seen low and the lever at idle;
            // the lever is then processed on the same tick.
            if (stop_cleared_d && lever_code_i == tldc_pkg::LEVER_IDLE) begin
              mode_d    = tldc_pkg::MODE_NORMAL;
              lever_run = 1'b1;
            end
          end
        end
        default: begin
          // No-input lockout is latched; nothing changes.
        end
      endcase
    end

    // Lever processing.
    if (lever_run) begin
      if (lever_changed) begin
        unique case (lever_code_i)
          tldc_pkg::LEVER_MAX_BRAKE: begin
            engine_d = tldc_pkg::ENGINE_OFF;
            brake_d  = tldc_pkg::BRAKE_MAX;
          end
          tldc_pkg::LEVER_MED_BRAKE: begin
            engine_d = tldc_pkg::ENGINE_OFF;
            brake_d  = tldc_pkg::BRAKE_MED;
          end
          tldc_pkg::LEVER_MIN_BRAKE: begin
            engine_d = tldc_pkg::ENGINE_OFF;
            brake_d  = tldc_pkg::BRAKE_MIN;
          end
          tldc_pkg::LEVER_IDLE: begin
            engine_d = tldc_pkg::ENGINE_OFF;
            brake_d  = tldc_pkg::BRAKE_OFF;
          end
          tldc_pkg::LEVER_MIN_ACCEL: begin
            engine_d = tldc_pkg::ENGINE_MIN;
            brake_d  = tldc_pkg::BRAKE_OFF;
          end
          tldc_pkg::LEVER_MED_ACCEL: begin
            engine_d = tldc_pkg::ENGINE_MED;
            brake_d  = tldc_pkg::BRAKE_OFF;
          end
          tldc_pkg::LEVER_MAX_ACCEL: begin
            engine_d    = tldc_pkg::ENGINE_MAX;
            brake_d     = tldc_pkg::BRAKE_OFF;
            accel_cnt_d = '0;
          end
          default: begin
            // Moving to no input leaves the drive as is.
            silence_cnt_d = '0;
          end
        endcase
        prev_lever_d = lever_code_i;
      end

      if (lever_code_i == tldc_pkg::LEVER_MAX_ACCEL) begin
        if (!lever_changed) begin
          accel_cnt_d = accel_cnt_inc;
        end
        if (accel_cnt_d >= max_accel_limit_q) begin
          engine_d = tldc_pkg::ENGINE_MED;
        end
      end

      if (lever_code_i == tldc_pkg::LEVER_NONE) begin
        if (!lever_changed) begin
          silence_cnt_d = silence_cnt_inc;
        end
        if (silence_cnt_d >= no_input_limit_q) begin
          engine_d = tldc_pkg::ENGINE_OFF;
          brake_d  = tldc_pkg::BRAKE_MED;
          mode_d   = tldc_pkg::MODE_SILENT;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_accel_limit_q <= tldc_pkg::MAX_ACCEL_LIMIT_RST;
      no_input_limit_q  <= tldc_pkg::NO_INPUT_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tldc_pkg::CFG_MAX_ACCEL_LIMIT: max_accel_limit_q <= cfg_data_i;
        tldc_pkg::CFG_NO_INPUT_LIMIT:  no_input_limit_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= tldc_pkg::MODE_NORMAL;
      stop_cleared_q <= 1'b0;
      prev_lever_q   <= tldc_pkg::LEVER_IDLE;
      engine_q       <= tldc_pkg::ENGINE_OFF;
      brake_q        <= tldc_pkg::BRAKE_OFF;
      accel_cnt_q    <= '0;
      silence_cnt_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (in_accept) begin
        mode_q         <= mode_d;
        stop_cleared_q <= stop_cleared_d;
        prev_lever_q   <= prev_lever_d;
        engine_q       <= engine_d;
        brake_q        <= brake_d;
        accel_cnt_q    <= accel_cnt_d;
        silence_cnt_q  <= silence_cnt_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign engine_level_o = engine_q;
  assign brake_level_o  = brake_q;
  assign drive_mode_o   = mode_q;

`ifndef SYNTHESIS
  // The emergency latch is only left through reset.
  a_emerg_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == tldc_pkg::MODE_EMERG |=> mode_q == tldc_pkg::MODE_EMERG)
    else $error("emergency latch was left");

  // An accepted emergency request yields an emergency result next cycle.
  a_emerg_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && emergency_request_i |=>
      out_valid_o && drive_mode_o == tldc_pkg::MODE_EMERG &&
      brake_level_o == tldc_pkg::BRAKE_EMERG &&
      engine_level_o == tldc_pkg::ENGINE_OFF)
    else $error("emergency request did not brake");

  // The engine is only driven in normal mode.
  a_engine_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    engine_q != tldc_pkg::ENGINE_OFF |-> mode_q == tldc_pkg::MODE_NORMAL)
    else $error("engine driven outside normal mode");

  // State only moves when a request is taken.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(mode_q) && $stable(engine_q) && $stable(brake_q))
    else $error("state changed without a request");
`endif

endmodule
